// ===== src/abmma_pkg.sv =====
// Shared types and constants for the ADC block mean / moving sum block.
`timescale 1ns / 1ps

package abmma_pkg;

  // Channel count and field widths
  localparam int NCH       = 3;
  localparam int SAMPLE_W  = 12;
  localparam int GAIN_W    = 10;
  localparam int ACC_W     = 20;
  localparam int PROD_W    = ACC_W + GAIN_W;
  localparam int MEAN_W    = 29;
  localparam int TOTAL_W   = 38;
  localparam int CFG_IDX_W = 2;

  // Fixed scale applied to every block mean
  localparam int SCALE = 100;

  typedef logic [SAMPLE_W-1:0]  sample_t;
  typedef logic [GAIN_W-1:0]    gain_t;
  typedef logic [MEAN_W-1:0]    mean_t;
  typedef logic [TOTAL_W-1:0]   total_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef logic [NCH-1:0][ACC_W-1:0]   acc_vec_t;
  typedef logic [NCH-1:0][GAIN_W-1:0]  gain_vec_t;
  typedef logic [NCH-1:0][MEAN_W-1:0]  mean_vec_t;
  typedef logic [NCH-1:0][TOTAL_W-1:0] total_vec_t;

  // Configuration register indexes
  localparam cfg_idx_t REG_GAIN_CH0 = 2'd0;
  localparam cfg_idx_t REG_GAIN_CH1 = 2'd1;
  localparam cfg_idx_t REG_GAIN_CH2 = 2'd2;

  localparam gain_t GAIN_RESET = 10'd1;

  // Largest mean: full-scale sample times largest gain times the scale
  localparam mean_t MEAN_MAX = 29'd418918500;

  // One scan frame
  typedef struct packed {
    sample_t sample_ch0;
    sample_t sample_ch1;
    sample_t sample_ch2;
  } frame_t;

  // One result beat
  typedef struct packed {
    mean_t  mean_ch0;
    mean_t  mean_ch1;
    mean_t  mean_ch2;
    total_t window_sum_ch0;
    total_t window_sum_ch1;
    total_t window_sum_ch2;
  } result_t;

endpackage

// ===== src/abmma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module abmma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port that returns the old contents on a collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/abmma_accum.sv =====
// Per-channel block accumulator and frame counter.
`timescale 1ns / 1ps

module abmma_accum #(
  parameter int BLOCK = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                frame_valid,
  output logic                frame_stall,
  input  abmma_pkg::frame_t   frame,
  output logic                blk_valid,
  input  logic                blk_stall,
  output abmma_pkg::acc_vec_t blk_sum
);

  import abmma_pkg::*;

  localparam int CW = (BLOCK > 1) ? $clog2(BLOCK) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(BLOCK - 1);

  acc_vec_t      acc;
  acc_vec_t      sum;
  logic [CW-1:0] cnt;
  logic          accept;
  logic          last;

  // Hold frames only while a finished block sum waits downstream
  assign frame_stall = blk_valid && blk_stall;
  assign accept      = frame_valid && !frame_stall;
  assign last        = (cnt == CNT_LAST);

  // Add this frame's samples
  always_comb begin
    sum[0] = acc[0] + ACC_W'(frame.sample_ch0);
    sum[1] = acc[1] + ACC_W'(frame.sample_ch1);
    sum[2] = acc[2] + ACC_W'(frame.sample_ch2);
  end

  // Advance the accumulators and the frame count, hand off a full block
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      cnt       <= '0;
      blk_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (last) begin
          acc <= '0;
          cnt <= '0;
        end else begin
          acc <= sum;
          cnt <= cnt + CW'(1);
        end
      end
      if (accept && last) begin
        blk_valid <= 1'b1;
      end else if (!blk_stall) begin
        blk_valid <= 1'b0;
      end
    end
  end

  // Capture the block sum
  always_ff @(posedge clk) begin
    if (accept && last) begin
      blk_sum <= sum;
    end
  end

endmodule

// ===== src/abmma_scale.sv =====
// Scaled block mean pipeline: sum times gain times 100, divided by BLOCK.
`timescale 1ns / 1ps

module abmma_scale #(
  parameter int BLOCK = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  abmma_pkg::gain_vec_t gain,
  input  logic                 up_valid,
  output logic                 up_stall,
  input  abmma_pkg::acc_vec_t  up_sum,
  output logic                 dn_valid,
  input  logic                 dn_stall,
  output abmma_pkg::mean_vec_t dn_mean
);

  import abmma_pkg::*;

  // Quotient of the product by BLOCK through an exact reciprocal multiply
  localparam int L       = (BLOCK > 1) ? $clog2(BLOCK) : 0;
  localparam int RW      = (BLOCK > 1) ? $clog2(BLOCK) : 1;
  localparam int Q_SHIFT = PROD_W + L;
  localparam int QR_W    = PROD_W + 1;
  localparam int QP_W    = PROD_W + QR_W;
  localparam longint unsigned Q_RECIP_L =
    ((64'd1 << Q_SHIFT) + 64'(BLOCK) - 64'd1) / 64'(BLOCK);
  localparam logic [QR_W-1:0] Q_RECIP = QR_W'(Q_RECIP_L);

  // Remainder times the scale, divided by BLOCK, the same way
  localparam int F_W      = $clog2(SCALE * BLOCK);
  localparam int F_SHIFT  = F_W + L;
  localparam int FM_W     = F_W + 8;
  localparam int FP_W     = RW + FM_W;
  localparam longint unsigned F_RECIP_L =
    ((64'd1 << F_SHIFT) + 64'(BLOCK) - 64'd1) / 64'(BLOCK);
  localparam logic [FM_W-1:0] F_MULT = FM_W'(F_RECIP_L * 64'(SCALE));

  logic                   v1, v2, v3, v4;
  logic                   r1, r2, r3, r4;
  logic [PROD_W-1:0]      p1 [NCH];
  logic [PROD_W-1:0]      p2 [NCH];
  logic [PROD_W-1:0]      qp2 [NCH];
  logic [RW-1:0]          rp3 [NCH];
  mean_t                  qs3 [NCH];
  mean_vec_t              mean4;
  logic [QP_W-1:0]        qprod [NCH];
  logic [FP_W-1:0]        fprod [NCH];

  // Stage readiness from the far end backward
  assign r4       = !v4 || !dn_stall;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign up_stall = !r1;
  assign dn_valid = v4;
  assign dn_mean  = mean4;

  // Reciprocal products
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      qprod[c] = QP_W'(p1[c]) * QP_W'(Q_RECIP);
      fprod[c] = FP_W'(rp3[c]) * FP_W'(F_MULT);
    end
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= up_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  // Stage payloads: product, quotient, remainder, mean
  always_ff @(posedge clk) begin
    for (int c = 0; c < NCH; c++) begin
      if (r1) begin
        p1[c] <= PROD_W'(up_sum[c]) * PROD_W'(gain[c]);
      end
      if (r2) begin
        p2[c]  <= p1[c];
        qp2[c] <= PROD_W'(qprod[c] >> Q_SHIFT);
      end
      if (r3) begin
        rp3[c] <= RW'(p2[c] - qp2[c] * PROD_W'(BLOCK));
        qs3[c] <= MEAN_W'(qp2[c] * PROD_W'(SCALE));
      end
      if (r4) begin
        mean4[c] <= qs3[c] + MEAN_W'(fprod[c] >> F_SHIFT);
      end
    end
  end

endmodule

// ===== src/abmma_window.sv =====
// Mean ring memory, running window sums and the result register.
`timescale 1ns / 1ps

module abmma_window #(
  parameter int WINDOW = 500
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_stall,
  input  abmma_pkg::mean_vec_t up_mean,
  output logic                 result_valid,
  input  logic                 result_stall,
  output abmma_pkg::result_t   result
);

  import abmma_pkg::*;

  localparam int PW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int RING_W = NCH * MEAN_W;
  localparam logic [PW-1:0] POS_LAST = PW'(WINDOW - 1);

  logic          out_ready;
  logic          w_ready;
  logic          w_load;
  logic          w_fire;
  logic [PW-1:0] pos;
  logic          wrapped;
  logic          w_valid;
  mean_vec_t     w_mean;
  logic [PW-1:0] w_pos;
  logic          w_filled;
  logic          w_byp;
  mean_vec_t     w_byp_data;
  mean_vec_t     ring_q;
  mean_vec_t     old;
  total_vec_t    total;
  total_vec_t    total_next;

  assign out_ready = !result_valid || !result_stall;
  assign w_ready   = !w_valid || out_ready;
  assign w_load    = up_valid && w_ready;
  assign w_fire    = w_valid && out_ready;
  assign up_stall  = !w_ready;

  // Ring: one row per slot, all three channels side by side
  abmma_ram #(
    .WIDTH (RING_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (w_fire),
    .wr_addr (w_pos),
    .wr_data (w_mean),
    .rd_en   (w_load),
    .rd_addr (pos),
    .rd_data (ring_q)
  );

  // Pick the replaced mean: zero before the first wrap, forwarded on a collision
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (!w_filled) begin
        old[c] = '0;
      end else if (w_byp) begin
        old[c] = w_byp_data[c];
      end else begin
        old[c] = ring_q[c];
      end
      total_next[c] = total[c] + TOTAL_W'(w_mean[c]) - TOTAL_W'(old[c]);
    end
  end

  // Control: slot pointer, wrap flag, stage and result valids, totals
  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      wrapped      <= 1'b0;
      w_valid      <= 1'b0;
      result_valid <= 1'b0;
      total        <= '0;
    end else begin
      if (w_load) begin
        if (pos == POS_LAST) begin
          pos     <= '0;
          wrapped <= 1'b1;
        end else begin
          pos <= pos + PW'(1);
        end
      end
      if (w_ready) begin
        w_valid <= up_valid;
      end
      if (out_ready) begin
        result_valid <= w_valid;
      end
      if (w_fire) begin
        total <= total_next;
      end
    end
  end

  // Payload of the ring stage, with the bypass for a same-slot write
  always_ff @(posedge clk) begin
    if (w_load) begin
      w_mean     <= up_mean;
      w_pos      <= pos;
      w_filled   <= wrapped;
      w_byp      <= w_fire && (w_pos == pos);
      w_byp_data <= w_mean;
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (w_fire) begin
      result.mean_ch0       <= w_mean[0];
      result.mean_ch1       <= w_mean[1];
      result.mean_ch2       <= w_mean[2];
      result.window_sum_ch0 <= total_next[0];
      result.window_sum_ch1 <= total_next[1];
      result.window_sum_ch2 <= total_next[2];
    end
  end

endmodule

// ===== src/adc_block_mean_moving_average.sv =====
// Top level of the three-channel ADC block mean and moving window sum.
`timescale 1ns / 1ps

// Takes one scan frame of three 12-bit samples per beat and sums BLOCK frames
// per channel. On the frame that closes a block it forms each channel's mean
// as sum * gain * 100 / BLOCK (truncated), pushes it into a WINDOW-deep ring
// and emits the three means with the three sums over the last WINDOW means.
// A frame is taken every clock while frame_stall is low; the result beat of a
// block passes the block sum register, the four-stage mean pipeline (gain
// multiply, reciprocal multiply, remainder, mean), the ring memory read stage
// and the result register. While results are stalled, the pipeline fills and
// then the frame side stalls. The ring needs no clearing pass after reset:
// slots not yet written since reset read as zero through a wrap flag. Gain
// writes take effect on the next completed block.
module adc_block_mean_moving_average #(
  parameter int BLOCK  = 16,
  parameter int WINDOW = 500
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 frame_valid,
  output logic                 frame_stall,
  input  abmma_pkg::frame_t    frame,
  output logic                 result_valid,
  input  logic                 result_stall,
  output abmma_pkg::result_t   result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  abmma_pkg::cfg_idx_t  cfg_index,
  input  abmma_pkg::gain_t     cfg_data
);

  import abmma_pkg::*;

  gain_vec_t gain;
  logic      blk_valid;
  logic      blk_stall;
  acc_vec_t  blk_sum;
  logic      mean_valid;
  logic      mean_stall;
  mean_vec_t mean;

  assign cfg_ready = 1'b1;

  // Gain registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= {NCH{GAIN_RESET}};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_CH0: gain[0] <= cfg_data;
        REG_GAIN_CH1: gain[1] <= cfg_data;
        REG_GAIN_CH2: gain[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  abmma_accum #(
    .BLOCK (BLOCK)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame       (frame),
    .blk_valid   (blk_valid),
    .blk_stall   (blk_stall),
    .blk_sum     (blk_sum)
  );

  abmma_scale #(
    .BLOCK (BLOCK)
  ) u_scale (
    .clk      (clk),
    .rst      (rst),
    .gain     (gain),
    .up_valid (blk_valid),
    .up_stall (blk_stall),
    .up_sum   (blk_sum),
    .dn_valid (mean_valid),
    .dn_stall (mean_stall),
    .dn_mean  (mean)
  );

  abmma_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (mean_valid),
    .up_stall     (mean_stall),
    .up_mean      (mean),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef ASSERT_OFF
  a_mean_range: assert property (@(posedge clk) disable iff (rst)
    mean_valid |-> (mean[0] <= MEAN_MAX) && (mean[1] <= MEAN_MAX) &&
                   (mean[2] <= MEAN_MAX))
    else $error("block mean above full-scale bound");

  a_frame_hold: assert property (@(posedge clk) disable iff (rst)
    frame_stall |-> blk_valid)
    else $error("frames stalled with no block sum pending");

  a_gain_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (cfg_index == REG_GAIN_CH1) |=> gain[1] == $past(cfg_data))
    else $error("gain write to channel 1 lost");

  a_single_slot: assert property (@(posedge clk) disable iff (rst)
    result_valid && (WINDOW == 1) |-> result.window_sum_ch0 == TOTAL_W'(result.mean_ch0))
    else $error("one-slot window sum differs from the mean");
`endif

endmodule
